// ===== src/exp_ts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_ts_pkg
// Shared widths, register indexes and microcode definitions for the
// exponential Taylor series core.
// ----------------------------------------------------------------------------
package exp_ts_pkg;

   // argument, term, sum and divider widths
   localparam int X_W        = 32;
   localparam int TMAG_W     = 42;
   localparam int SUM_W      = 64;
   localparam int PROD_W     = 64;
   localparam int FULL_W     = 74;
   localparam int FRAC_SHIFT = 28;
   localparam int DVD_W      = 48;
   localparam int DIV_DIGIT  = 8;
   localparam int DIV_PASSES = DVD_W / DIV_DIGIT;
   localparam int DCNT_W     = 3;

   // configuration registers
   localparam int TOL_W       = 32;
   localparam int TL_W        = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_LIMIT = 1'd1;
   localparam logic [TOL_W-1:0]     TOL_RESET      = 32'd1;
   localparam logic [TL_W-1:0]      TL_RESET       = 7'd64;

   // microcode program counter
   localparam int PC_W = 3;

   // datapath action of one control word
   typedef enum logic [2:0] {
      OP_WAIT   = 3'd0,
      OP_MUL_LO = 3'd1,
      OP_MUL_HI = 3'd2,
      OP_DIV    = 3'd3,
      OP_ACC    = 3'd4,
      OP_NEXT   = 3'd5,
      OP_EMIT   = 3'd6,
      OP_NOP    = 3'd7
   } op_type;

   // jump condition of one control word
   typedef enum logic [2:0] {
      COND_NEVER    = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_NO_REQ   = 3'd2,
      COND_DIV_BUSY = 3'd3,
      COND_STOP     = 3'd4,
      COND_OUT_BUSY = 3'd5
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   // step addresses
   localparam logic [PC_W-1:0] ST_WAIT   = 3'd0;
   localparam logic [PC_W-1:0] ST_MUL_LO = 3'd1;
   localparam logic [PC_W-1:0] ST_MUL_HI = 3'd2;
   localparam logic [PC_W-1:0] ST_DIV    = 3'd3;
   localparam logic [PC_W-1:0] ST_ACC    = 3'd4;
   localparam logic [PC_W-1:0] ST_NEXT   = 3'd5;
   localparam logic [PC_W-1:0] ST_EMIT   = 3'd6;
   localparam logic [PC_W-1:0] ST_NOP    = 3'd7;

   // control store: one word per step, jump to target when cond holds
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] addr);
      ucode_type w;
      case (addr)
         ST_WAIT:   w = '{OP_WAIT,   COND_NO_REQ,   ST_WAIT};
         ST_MUL_LO: w = '{OP_MUL_LO, COND_NEVER,    ST_WAIT};
         ST_MUL_HI: w = '{OP_MUL_HI, COND_NEVER,    ST_WAIT};
         ST_DIV:    w = '{OP_DIV,    COND_DIV_BUSY, ST_DIV};
         ST_ACC:    w = '{OP_ACC,    COND_STOP,     ST_EMIT};
         ST_NEXT:   w = '{OP_NEXT,   COND_ALWAYS,   ST_MUL_LO};
         ST_EMIT:   w = '{OP_EMIT,   COND_OUT_BUSY, ST_EMIT};
         ST_NOP:    w = '{OP_NOP,    COND_ALWAYS,   ST_WAIT};
         default:   w = '{OP_NOP,    COND_ALWAYS,   ST_WAIT};
      endcase
      return w;
   endfunction

endpackage

// ===== src/exp_taylor_series_tolerance_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_taylor_series_tolerance_core
// Fixed-point exp(x) by the Maclaurin series, stopping on a term tolerance.
// ----------------------------------------------------------------------------
// Takes x in signed Q3.28 and returns exp(x) in unsigned Q32.32 (negative sums
// clamp to zero), the index of the term where summing stopped and a flag set
// when the term limit was reached first. Each term is formed from the last as
// term * |x| / k, truncated toward zero, by a small microcoded sequencer over
// one 32x32 multiplier (two passes per term) and an 8-bit-per-cycle divider
// (six passes per term). The divider passes take most of the time spent on
// each of the n terms computed (at most the term limit). A new item is taken
// once the previous result sits in the output register and the sequencer has
// stepped through NOP back to WAIT, even while that result waits to be read.
// ----------------------------------------------------------------------------
module exp_taylor_series_tolerance_core
   import exp_ts_pkg::*;
#(
   parameter int MAX_TERMS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // argument channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [X_W-1:0] req_x,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SUM_W-1:0]      rsp_exp_value,
   output logic [TL_W-1:0]       rsp_terms_used,
   output logic                  rsp_not_converged,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int KW = $clog2(MAX_TERMS + 1);
   localparam int LW = (KW > TL_W) ? KW : TL_W;

   // sequencer
   logic [PC_W-1:0]   pc_ff, pc_in;
   ucode_type         cw;
   logic              jump;

   // configuration
   logic [TOL_W-1:0]  tol_ff, tol_in;
   logic [TL_W-1:0]   term_limit_ff, term_limit_in;

   // datapath
   logic [X_W-1:0]    xmag_ff, xmag_in;
   logic              xneg_ff, xneg_in;
   logic [KW-1:0]     limit_ff, limit_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [TMAG_W-1:0] tmag_ff, tmag_in;
   logic              tneg_ff, tneg_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [KW-1:0]     rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [KW-1:0]     used_ff, used_in;
   logic              missed_ff, missed_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [TL_W-1:0]   rsp_used_ff, rsp_used_in;
   logic              rsp_missed_ff, rsp_missed_in;

   // combinational helpers
   logic [LW-1:0]     lim_wide;
   logic [KW-1:0]     limit_calc;
   logic [X_W-1:0]    xmag_calc;
   logic [PROD_W-1:0] mul_lo;
   logic [TMAG_W-1:0] mul_hi;
   logic [FULL_W-1:0] full_prod;
   logic [KW:0]       div_r;
   logic [DVD_W-1:0]  div_d;
   logic              below_tol;
   logic              at_limit;
   logic              stop;
   logic              tneg_next;
   logic [SUM_W-1:0]  tmag_ext;
   logic [LW-1:0]     used_wide;
   logic              out_busy;
   logic              emit_load;

   // fetch control word
   assign cw        = ucode_rom(pc_ff);
   assign req_ready = (cw.op == OP_WAIT);
   assign csr_ready = 1'b1;
   assign out_busy  = rsp_valid_ff && !rsp_ready;

   // effective term limit: zero acts as one, clip at MAX_TERMS
   always_comb begin
      lim_wide = LW'(term_limit_ff);
      if (lim_wide == '0) begin
         lim_wide = LW'(1);
      end else if (lim_wide > LW'(MAX_TERMS)) begin
         lim_wide = LW'(MAX_TERMS);
      end
      limit_calc = lim_wide[KW-1:0];
   end

   // argument magnitude; the most negative code negates onto itself
   assign xmag_calc = req_x[X_W-1] ? (~req_x + X_W'(1)) : req_x;

   // multiplier passes: low 32 bits of the term, then its high bits
   assign mul_lo    = PROD_W'(tmag_ff[31:0]) * PROD_W'(xmag_ff);
   assign mul_hi    = TMAG_W'(tmag_ff[TMAG_W-1:32]) * TMAG_W'(xmag_ff);
   assign full_prod = {mul_hi, 32'd0} + FULL_W'(prod_ff);

   // divider: eight restoring steps per pass, quotient shifts into dvd_ff
   always_comb begin
      div_r = {1'b0, rem_ff};
      div_d = dvd_ff;
      for (int j = 0; j < DIV_DIGIT; j++) begin
         div_r = {div_r[KW-1:0], div_d[DVD_W-1]};
         div_d = {div_d[DVD_W-2:0], 1'b0};
         if (div_r >= {1'b0, k_ff}) begin
            div_r    = div_r - {1'b0, k_ff};
            div_d[0] = 1'b1;
         end
      end
   end

   // stop test on the new term
   assign below_tol = (dvd_ff < DVD_W'(tol_ff));
   assign at_limit  = (k_ff == limit_ff);
   assign stop      = below_tol || at_limit;
   assign tneg_next = tneg_ff ^ xneg_ff;
   assign tmag_ext  = SUM_W'(dvd_ff[TMAG_W-1:0]);

   // jump condition
   always_comb begin
      case (cw.cond)
         COND_NEVER:    jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_REQ:   jump = !req_valid;
         COND_DIV_BUSY: jump = (dcnt_ff != DCNT_W'(DIV_PASSES - 1));
         COND_STOP:     jump = stop;
         COND_OUT_BUSY: jump = out_busy;
         default:       jump = 1'b0;
      endcase
   end

   assign pc_in     = jump ? cw.target : pc_ff + PC_W'(1);
   assign emit_load = (cw.op == OP_EMIT) && !out_busy;

   // configuration writes
   always_comb begin
      tol_in        = tol_ff;
      term_limit_in = term_limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TOLERANCE:  tol_in        = csr_data[TOL_W-1:0];
            CSR_TERM_LIMIT: term_limit_in = csr_data[TL_W-1:0];
            default:        tol_in        = tol_ff;
         endcase
      end
   end

   // datapath actions per control word
   always_comb begin
      xmag_in   = xmag_ff;
      xneg_in   = xneg_ff;
      limit_in  = limit_ff;
      k_in      = k_ff;
      tmag_in   = tmag_ff;
      tneg_in   = tneg_ff;
      sum_in    = sum_ff;
      prod_in   = prod_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      dcnt_in   = dcnt_ff;
      used_in   = used_ff;
      missed_in = missed_ff;
      case (cw.op)
         OP_WAIT: begin
            if (req_valid) begin
               xmag_in  = xmag_calc;
               xneg_in  = req_x[X_W-1];
               limit_in = limit_calc;
               k_in     = KW'(1);
               tmag_in  = TMAG_W'(64'd1 << 32);
               tneg_in  = 1'b0;
               sum_in   = SUM_W'(64'd1 << 32);
            end
         end
         OP_MUL_LO: begin
            prod_in = mul_lo;
         end
         OP_MUL_HI: begin
            dvd_in  = DVD_W'(full_prod[FULL_W-1:FRAC_SHIFT]);
            rem_in  = '0;
            dcnt_in = '0;
         end
         OP_DIV: begin
            dvd_in  = div_d;
            rem_in  = div_r[KW-1:0];
            dcnt_in = dcnt_ff + DCNT_W'(1);
         end
         OP_ACC: begin
            if (below_tol) begin
               used_in   = k_ff;
               missed_in = 1'b0;
            end else begin
               tmag_in = dvd_ff[TMAG_W-1:0];
               tneg_in = tneg_next;
               sum_in  = tneg_next ? (sum_ff - tmag_ext) : (sum_ff + tmag_ext);
               if (at_limit) begin
                  used_in   = limit_ff;
                  missed_in = 1'b1;
               end
            end
         end
         OP_NEXT: begin
            k_in = k_ff + KW'(1);
         end
         default: begin
            k_in = k_ff;
         end
      endcase
   end

   // result register: load on emit, drop when the transaction completes
   assign used_wide = LW'(used_ff);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_missed_in = rsp_missed_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = sum_ff[SUM_W-1] ? '0 : sum_ff;
         rsp_used_in   = used_wide[TL_W-1:0];
         rsp_missed_in = missed_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= ST_WAIT;
         rsp_valid_ff  <= 1'b0;
         tol_ff        <= TOL_RESET;
         term_limit_ff <= TL_RESET;
      end else begin
         pc_ff         <= pc_in;
         rsp_valid_ff  <= rsp_valid_in;
         tol_ff        <= tol_in;
         term_limit_ff <= term_limit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      xmag_ff       <= xmag_in;
      xneg_ff       <= xneg_in;
      limit_ff      <= limit_in;
      k_ff          <= k_in;
      tmag_ff       <= tmag_in;
      tneg_ff       <= tneg_in;
      sum_ff        <= sum_in;
      prod_ff       <= prod_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      dcnt_ff       <= dcnt_in;
      used_ff       <= used_in;
      missed_ff     <= missed_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_missed_ff <= rsp_missed_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_exp_value     = rsp_value_ff;
   assign rsp_terms_used    = rsp_used_ff;
   assign rsp_not_converged = rsp_missed_ff;

endmodule

// ===== dv/exp_ts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_ts_checker
// Watches the argument, result and register channels of the exp(x) series
// core, predicts every result from a fixed-point series sum of its own and
// compares each returned transaction field by field, oldest first.
// ----------------------------------------------------------------------------
module exp_ts_checker
   import exp_ts_pkg::*;
#(
   parameter int MAX_TERMS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [X_W-1:0]        req_x,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [SUM_W-1:0]      rsp_exp_value,
   input  logic [TL_W-1:0]       rsp_terms_used,
   input  logic                  rsp_not_converged,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    pending,
   output int                    fail_count
);

   typedef struct packed {
      logic [SUM_W-1:0] value;
      logic [TL_W-1:0]  terms;
      logic             missed;
   } exp_result_type;

   logic [TOL_W-1:0] tolerance_q;
   logic [TL_W-1:0]  term_limit_q;
   exp_result_type   expected_q[$];
   exp_result_type   oldest;

   // Sum 1 + x + x^2/2! + ... on magnitudes, one truncation per term
   function automatic exp_result_type series_exp(input logic [X_W-1:0] x,
                                                 input logic [TOL_W-1:0] tol,
                                                 input logic [TL_W-1:0] tl);
      exp_result_type    r;
      logic              x_neg;
      logic [X_W-1:0]    x_mag;
      logic [63:0]       limit;
      logic [63:0]       k;
      logic [63:0]       term;
      logic [63:0]       sum;
      logic [FULL_W-1:0] prod;
      logic [FULL_W-1:0] scaled;
      logic              term_neg;
      logic              done;
      x_neg = x[X_W-1];
      x_mag = x_neg ? (~x + 1'b1) : x;
      // a zero limit still computes one term; large limits saturate
      if (tl == 0)
         limit = 64'd1;
      else if (tl > MAX_TERMS)
         limit = 64'(MAX_TERMS);
      else
         limit = {57'd0, tl};
      term     = 64'd1 << 32;
      sum      = 64'd1 << 32;
      term_neg = 1'b0;
      done     = 1'b0;
      r.terms  = limit[TL_W-1:0];
      r.missed = 1'b1;
      for (k = 64'd1; k <= limit && !done; k++) begin
         prod     = term * x_mag;
         scaled   = prod >> FRAC_SHIFT;
         term     = scaled[63:0] / k;
         term_neg = term_neg ^ x_neg;
         // stop on the first term below tolerance, without adding it
         if (term < {32'd0, tol}) begin
            r.terms  = k[TL_W-1:0];
            r.missed = 1'b0;
            done     = 1'b1;
         end else if (term_neg) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      // clamp a negative sum to zero
      r.value = sum[63] ? '0 : sum;
      return r;
   endfunction

   // Track register writes, queue predictions, check results
   always @(posedge clock) begin
      if (reset) begin
         tolerance_q  <= TOL_RESET;
         term_limit_q <= TL_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TOLERANCE:  tolerance_q  <= csr_data[TOL_W-1:0];
               CSR_TERM_LIMIT: term_limit_q <= csr_data[TL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_q.push_back(series_exp(req_x, tolerance_q, term_limit_q));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result transaction: exp_value %h", rsp_exp_value);
               fail_count++;
            end else begin
               oldest = expected_q.pop_front();
               if (rsp_exp_value !== oldest.value) begin
                  $error("exp_value mismatch: expected %h, actual %h",
                         oldest.value, rsp_exp_value);
                  fail_count++;
               end
               if (rsp_terms_used !== oldest.terms) begin
                  $error("terms_used mismatch: expected %0d, actual %0d",
                         oldest.terms, rsp_terms_used);
                  fail_count++;
               end
               if (rsp_not_converged !== oldest.missed) begin
                  $error("not_converged mismatch: expected %b, actual %b",
                         oldest.missed, rsp_not_converged);
                  fail_count++;
               end
            end
         end
         pending = expected_q.size();
      end
   end

endmodule

// ===== dv/exp_taylor_series_tolerance_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_taylor_series_tolerance_core_tb
// Stimulus and verdict for the exp(x) series core.
// ----------------------------------------------------------------------------
// Runs a set of phases, each under its own tolerance and term limit: corner
// arguments first, then random arguments, with random idle cycles on both
// channels. Registers change only once every result of the phase is back.
// The checker beside the core predicts and compares every transaction.
// ----------------------------------------------------------------------------
module exp_taylor_series_tolerance_core_tb;
   import exp_ts_pkg::*;

   localparam int MAX_TERMS      = 64;
   localparam int IDLE_PCT       = 21;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 700;
   localparam int NUM_CORNERS    = 21;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic signed [X_W-1:0] req_x = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [SUM_W-1:0]      rsp_exp_value;
   logic [TL_W-1:0]       rsp_terms_used;
   logic                  rsp_not_converged;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_TOLERANCE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic                  calm = 1'b0;
   int                    stall_cycles = 0;
   int                    pending;
   int                    fail_count;

   // zero, smallest steps, +-1, +-2, +-4, range ends and bit patterns
   logic [X_W-1:0] corner_x [NUM_CORNERS] = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1000_0000,
      32'hF000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0800_0000,
      32'hF800_0000, 32'h2000_0000, 32'hE000_0000, 32'h4000_0000,
      32'hC000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000,
      32'hFFFF_0000, 32'h0FFF_FFFF, 32'h8000_0001, 32'h7000_0000,
      32'h9000_0000
   };

   initial begin
      forever #2 clock = ~clock;
   end

   exp_taylor_series_tolerance_core #(
      .MAX_TERMS(MAX_TERMS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_x            (req_x),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_exp_value    (rsp_exp_value),
      .rsp_terms_used   (rsp_terms_used),
      .rsp_not_converged(rsp_not_converged),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   exp_ts_checker #(
      .MAX_TERMS(MAX_TERMS)
   ) u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_x            (req_x),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_exp_value    (rsp_exp_value),
      .rsp_terms_used   (rsp_terms_used),
      .rsp_not_converged(rsp_not_converged),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .pending          (pending),
      .fail_count       (fail_count)
   );

   // Stall the result channel at random, except in calm stretches
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offer one argument, idling first at random; valid stays high on return
   task automatic send_x(input logic [X_W-1:0] v);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x     <= v;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   // Write one register; the caller drops valid after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
   endtask

   // Configure, send corners and random arguments, then drain all results
   task automatic run_phase(input bit write_cfg, input logic [31:0] tol_data,
                            input logic [31:0] limit_data, input bit with_corners,
                            input int n_rand, input bit no_idle);
      logic [X_W-1:0] v;
      if (write_cfg) begin
         write_reg(CSR_TOLERANCE, tol_data);
         write_reg(CSR_TERM_LIMIT, limit_data);
         csr_valid <= 1'b0;
      end
      calm <= no_idle;
      if (with_corners) begin
         for (int i = 0; i < NUM_CORNERS; i++)
            send_x(corner_x[i]);
      end
      for (int n = 0; n < n_rand; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = $urandom;
            6, 7: begin
               v = $urandom_range(0, 32'h0100_0000);
               if ($urandom_range(0, 1) == 1)
                  v = ~v + 1'b1;
            end
            default: begin
               v = $urandom_range(0, 255);
               v = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF - v : 32'h8000_0000 + v;
            end
         endcase
         send_x(v);
      end
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      logic [31:0] tol_data;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // reset register values
      run_phase(1'b0, 32'd0, 32'd0, 1'b1, 40, 1'b0);
      // zero tolerance: always runs to the limit
      run_phase(1'b1, 32'd0, 32'd64, 1'b1, 10, 1'b0);
      // zero limit acts as one term; arguments below -1 clamp to zero
      run_phase(1'b1, 32'd0, 32'hFFFF_FF00, 1'b1, 30, 1'b0);
      // largest tolerance
      run_phase(1'b1, 32'hFFFF_FFFF, 32'd1, 1'b0, 30, 1'b0);
      run_phase(1'b1, 32'hFFFF_FFFF, 32'd64, 1'b0, 20, 1'b0);
      // limit of 127 saturates; no idling on either side
      run_phase(1'b1, 32'd1, 32'hFFFF_FFFF, 1'b0, 60, 1'b1);
      // random settings
      for (int p = 0; p < 8; p++) begin
         case ($urandom_range(0, 2))
            0:       tol_data = $urandom_range(0, 255);
            1:       tol_data = 32'd1 << $urandom_range(0, 31);
            default: tol_data = $urandom;
         endcase
         run_phase(1'b1, tol_data, ($urandom & 32'hFFFF_FF80) | $urandom_range(0, 127),
                   1'b0, 50, 1'b0);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/exp_ts_pkg.sv
src/exp_taylor_series_tolerance_core.sv
dv/exp_ts_checker.sv
dv/exp_taylor_series_tolerance_core_tb.sv
